>>> rtl/core/rdp_pkg.sv
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared types and constants of the reuse distance profiler.
// ----------------------------------------------------------------------------
package rdp_pkg;

  localparam int STACK_DEPTH      = 64;
  localparam int ADDRESS_BITS     = 16;
  localparam int MAX_RECORD_BYTES = 64;

  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int DIST_W = $clog2(STACK_DEPTH + 1);
  localparam int HB     = STACK_DEPTH + 1;
  localparam int HB_W   = $clog2(HB);
  localparam int SEEN_DEPTH = 1 << ADDRESS_BITS;

  // Sum of all 32-bit histogram bins, and that sum scaled by 20.
  localparam int CNT_SUM_W = 32 + HB_W;
  localparam int RANK_W    = CNT_SUM_W + 5;

  localparam logic [12:0] BLOCK_SIZE_RESET = 13'd64;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [6:0]  size;
  } in_item_t;

  typedef struct packed {
    logic        is_report;
    logic [15:0] block_number;
    logic        cold;
    logic [6:0]  distance;
    logic        last;
    logic [31:0] total_accesses;
    logic [31:0] cold_count;
    logic [31:0] reused_count;
    logic [39:0] distance_sum;
    logic [6:0]  half_rank_dist;
    logic [6:0]  tail_rank_dist;
    logic [6:0]  max_distance;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DIV0, ST_DIV1, ST_DIVW, ST_BLK, ST_SEARCH, ST_SRD,
    ST_MOVE, ST_MOVEW, ST_HRD, ST_HUPD, ST_EMIT,
    ST_RSUM, ST_RSUMW, ST_RSEL, ST_RSELW, ST_REMIT
  } state_t;

endpackage

>>> rtl/core/rdp_if.sv
// ----------------------------------------------------------------------------
// rdp_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface rdp_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/reuse_distance_profiler_core.sv
// ----------------------------------------------------------------------------
// reuse_distance_profiler_core
// LRU stack distance profiler with summary report.
// ----------------------------------------------------------------------------
// After reset the block clears its whole seen map before it takes an item.
// Each access record first runs the two divisions that give the first and
// last block, then per block a serial search of the recency stack and a
// move-to-front that shifts entries through the single stack RAM port, and
// then the histogram update and the result. A result waits in the output
// register until it is taken, and the next block only stalls if that
// register is still full. A report walks the 65-bin histogram twice, once
// to count the reuses and once to pick the median and p95 bins. The
// percentile ranks are found by comparing shifted sums, so no division is
// needed there.
module reuse_distance_profiler_core (
  input  logic clk,
  input  logic rst_n,
  rdp_if.sink   in_ch,
  rdp_if.source out_ch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);
  localparam int SPW = rdp_pkg::SP_W;
  localparam int DW  = rdp_pkg::DIST_W;
  localparam int HW  = rdp_pkg::HB_W;
  localparam int AB  = rdp_pkg::ADDRESS_BITS;
  localparam int NW  = rdp_pkg::CNT_SUM_W;
  localparam int RW  = rdp_pkg::RANK_W;

  rdp_pkg::state_t st_r, st_nxt;

  logic [12:0] bs_r;
  logic [AB-1:0] addr_r, endb_r, blk_r, lastb_r;
  logic [SPW:0] fill_r;
  logic [SPW:0] idx_r;
  logic [SPW-1:0] pos_r;
  logic [DW-1:0]  dist_r;
  logic seen_r;
  logic [31:0] acc_r, coldc_r;
  logic [39:0] dtot_r;
  logic [DW-1:0] maxd_r;
  logic [NW-1:0] n_r, cum_r, cum_next;
  logic [RW-1:0] rank_r, n_less1, n19, cum20;
  logic half_hit, tail_hit;
  logic med_set_r, tail_set_r;
  logic [DW-1:0] med_r, tail_r;
  logic [HW-1:0] hidx_r;
  logic hist_last;
  logic [15:0] clr_r;
  rdp_pkg::out_item_t out_r, acc_item, rep_item;
  logic out_v_r;

  // Stack RAM
  logic s_we; logic [SPW-1:0] s_addr; logic [AB-1:0] s_wd, s_rd;
  rdp_ram #(.WIDTH(AB), .DEPTH(rdp_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));
  // Histogram RAM, reset-valued via valid bits.
  logic h_we; logic [HW-1:0] h_addr; logic [31:0] h_wd, h_rd, h_val;
  logic [rdp_pkg::HB-1:0] hv_r;
  logic hvq_r;
  rdp_ram #(.WIDTH(32), .DEPTH(rdp_pkg::HB)) u_hist (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));
  assign h_val = hvq_r ? h_rd : 32'd0;
  // Seen map
  logic m_we; logic [AB-1:0] m_addr; logic m_wd, m_rd;
  rdp_ram #(.WIDTH(1), .DEPTH(rdp_pkg::SEEN_DEPTH)) u_seen (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
  // Divider
  logic d_start, d_busy; logic [23:0] d_num, d_q; logic [12:0] d_den;
  rdp_div u_div (.clk(clk), .rst_n(rst_n), .start(d_start), .dividend(d_num),
    .divisor(d_den), .busy(d_busy), .quotient(d_q));

  logic [6:0] sz;
  logic [AB:0] endsum;

  assign hist_last = (hidx_r == HW'(rdp_pkg::HB - 1));
  assign cum_next  = cum_r + NW'(h_val);

  // Median bin: first bin where n < 2*cum. p95 bin: first bin where
  // 19*(n-1) < 20*cum. Both follow from rank < cum with integer cum.
  assign n_less1  = (n_r == '0) ? '0 : RW'(n_r) - RW'(1);
  assign n19      = (n_less1 << 4) + (n_less1 << 1) + n_less1;
  assign cum20    = (RW'(cum_next) << 4) + (RW'(cum_next) << 2);
  assign half_hit = (RW'(cum_next) << 1) > RW'(n_r);
  assign tail_hit = cum20 > rank_r;

  assign in_ch.ready = (st_r == rdp_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.data = out_r;

  always_comb begin
    sz = in_ch.data.size;
    if (sz == 7'd0) sz = 7'd1;
    if (sz > 7'(rdp_pkg::MAX_RECORD_BYTES)) sz = 7'(rdp_pkg::MAX_RECORD_BYTES);
    endsum = {1'b0, in_ch.data.address[AB-1:0]} + (AB+1)'(sz) - (AB+1)'(1);
  end

  always_comb begin
    acc_item = '0;
    acc_item.block_number = 16'(blk_r);
    acc_item.cold = !seen_r;
    acc_item.distance = seen_r ? 7'(dist_r) : 7'd0;
    acc_item.last = (blk_r == lastb_r);
    rep_item = '0;
    rep_item.is_report = 1'b1;
    rep_item.last = 1'b1;
    rep_item.total_accesses = acc_r;
    rep_item.cold_count = coldc_r;
    rep_item.reused_count = (n_r > NW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : n_r[31:0];
    rep_item.distance_sum = dtot_r;
    if (n_r != '0) begin
      rep_item.half_rank_dist = 7'(med_r);
      rep_item.tail_rank_dist = 7'(tail_r);
      rep_item.max_distance = 7'(maxd_r);
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      rdp_pkg::ST_CLEAR: if (clr_r == 16'(rdp_pkg::SEEN_DEPTH - 1)) st_nxt = rdp_pkg::ST_IDLE;
      rdp_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready)
        st_nxt = in_ch.data.kind ? rdp_pkg::ST_RSUM : rdp_pkg::ST_DIV0;
      rdp_pkg::ST_DIV0: st_nxt = rdp_pkg::ST_DIV1;
      rdp_pkg::ST_DIV1: if (!d_busy) st_nxt = rdp_pkg::ST_DIVW;
      rdp_pkg::ST_DIVW: if (!d_busy) st_nxt = rdp_pkg::ST_BLK;
      rdp_pkg::ST_BLK: st_nxt = rdp_pkg::ST_SEARCH;
      rdp_pkg::ST_SEARCH: st_nxt = (idx_r >= fill_r) ? rdp_pkg::ST_MOVE : rdp_pkg::ST_SRD;
      rdp_pkg::ST_SRD: st_nxt = (s_rd == blk_r) ? rdp_pkg::ST_MOVE : rdp_pkg::ST_SEARCH;
      rdp_pkg::ST_MOVE: st_nxt = (pos_r == '0) ? rdp_pkg::ST_HRD : rdp_pkg::ST_MOVEW;
      rdp_pkg::ST_MOVEW: st_nxt = rdp_pkg::ST_MOVE;
      rdp_pkg::ST_HRD: st_nxt = rdp_pkg::ST_HUPD;
      rdp_pkg::ST_HUPD: st_nxt = rdp_pkg::ST_EMIT;
      rdp_pkg::ST_EMIT: if (!out_v_r)
        st_nxt = (blk_r == lastb_r) ? rdp_pkg::ST_IDLE : rdp_pkg::ST_BLK;
      rdp_pkg::ST_RSUM: st_nxt = rdp_pkg::ST_RSUMW;
      rdp_pkg::ST_RSUMW: st_nxt = hist_last ? rdp_pkg::ST_RSEL : rdp_pkg::ST_RSUM;
      rdp_pkg::ST_RSEL: st_nxt = rdp_pkg::ST_RSELW;
      rdp_pkg::ST_RSELW: st_nxt = hist_last ? rdp_pkg::ST_REMIT : rdp_pkg::ST_RSEL;
      rdp_pkg::ST_REMIT: if (!out_v_r) st_nxt = rdp_pkg::ST_IDLE;
      default: st_nxt = rdp_pkg::ST_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    s_we = 1'b0; s_addr = idx_r[SPW-1:0]; s_wd = s_rd;
    h_we = 1'b0; h_addr = hidx_r; h_wd = '0;
    m_we = 1'b0; m_addr = blk_r; m_wd = 1'b1;
    d_start = 1'b0; d_num = 24'(addr_r); d_den = bs_r;
    unique case (st_r)
      rdp_pkg::ST_CLEAR: begin m_we = 1'b1; m_addr = clr_r[AB-1:0]; m_wd = 1'b0; end
      rdp_pkg::ST_DIV0: d_start = 1'b1;
      rdp_pkg::ST_DIV1: if (!d_busy) begin d_start = 1'b1; d_num = 24'(endb_r); end
      rdp_pkg::ST_SEARCH: s_addr = idx_r[SPW-1:0];
      rdp_pkg::ST_MOVE: s_addr = (pos_r == '0) ? pos_r : pos_r - SPW'(1);
      rdp_pkg::ST_MOVEW: begin s_we = 1'b1; s_addr = pos_r; s_wd = s_rd; end
      rdp_pkg::ST_HRD: begin
        s_we = 1'b1; s_addr = '0; s_wd = blk_r;
        h_addr = HW'(dist_r);
        m_we = 1'b1;
      end
      rdp_pkg::ST_HUPD: begin
        h_addr = HW'(dist_r);
        h_we = seen_r;
        h_wd = (h_val == 32'hFFFF_FFFF) ? h_val : h_val + 32'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rdp_pkg::ST_CLEAR; clr_r <= '0; bs_r <= rdp_pkg::BLOCK_SIZE_RESET;
      fill_r <= '0; hv_r <= '0; acc_r <= '0; coldc_r <= '0; dtot_r <= '0;
      maxd_r <= '0; out_v_r <= 1'b0; hidx_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) bs_r <= (cfg_data == 13'd0) ? 13'd1 : cfg_data;
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      hvq_r <= hv_r[h_addr];
      unique case (st_r)
        rdp_pkg::ST_CLEAR: clr_r <= clr_r + 16'd1;
        rdp_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          addr_r <= in_ch.data.address[AB-1:0];
          endb_r <= endsum[AB] ? {AB{1'b1}} : endsum[AB-1:0];
          hidx_r <= '0; cum_r <= '0;
        end
        rdp_pkg::ST_DIV1: if (!d_busy) blk_r <= d_q[AB-1:0];
        rdp_pkg::ST_DIVW: if (!d_busy) lastb_r <= d_q[AB-1:0];
        rdp_pkg::ST_BLK: idx_r <= '0;
        rdp_pkg::ST_SEARCH: if (idx_r >= fill_r) begin
          dist_r <= DW'(rdp_pkg::STACK_DEPTH);
          if (fill_r < (SPW+1)'(rdp_pkg::STACK_DEPTH)) begin
            pos_r <= fill_r[SPW-1:0]; fill_r <= fill_r + (SPW+1)'(1);
          end else pos_r <= SPW'(rdp_pkg::STACK_DEPTH - 1);
        end
        rdp_pkg::ST_SRD: if (s_rd == blk_r) begin
          pos_r <= idx_r[SPW-1:0]; dist_r <= DW'(idx_r);
        end else idx_r <= idx_r + (SPW+1)'(1);
        rdp_pkg::ST_MOVEW: pos_r <= pos_r - SPW'(1);
        rdp_pkg::ST_HRD: seen_r <= m_rd;
        rdp_pkg::ST_HUPD: begin
          acc_r <= (acc_r == 32'hFFFF_FFFF) ? acc_r : acc_r + 32'd1;
          if (!seen_r) coldc_r <= (coldc_r == 32'hFFFF_FFFF) ? coldc_r : coldc_r + 32'd1;
          else begin
            hv_r[HW'(dist_r)] <= 1'b1;
            dtot_r <= ((41'(dtot_r) + 41'(dist_r)) > 41'h0FF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF
                      : dtot_r + 40'(dist_r);
            if (dist_r > maxd_r) maxd_r <= dist_r;
          end
        end
        rdp_pkg::ST_EMIT: if (!out_v_r) begin
          out_v_r <= 1'b1;
          out_r <= acc_item;
          blk_r <= blk_r + AB'(1);
        end
        rdp_pkg::ST_RSUMW: begin
          if (hist_last) begin
            n_r <= cum_next; cum_r <= '0; hidx_r <= '0;
            med_set_r <= 1'b0; tail_set_r <= 1'b0;
            med_r <= '0; tail_r <= '0;
          end else begin
            cum_r <= cum_next; hidx_r <= hidx_r + HW'(1);
          end
        end
        rdp_pkg::ST_RSEL: rank_r <= n19;
        rdp_pkg::ST_RSELW: begin
          if (!med_set_r && half_hit) begin med_r <= DW'(hidx_r); med_set_r <= 1'b1; end
          if (!tail_set_r && tail_hit) begin tail_r <= DW'(hidx_r); tail_set_r <= 1'b1; end
          cum_r <= cum_next;
          hidx_r <= hist_last ? '0 : hidx_r + HW'(1);
        end
        rdp_pkg::ST_REMIT: if (!out_v_r) begin
          out_v_r <= 1'b1;
          out_r <= rep_item;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/core/rdp_ram.sv
// ----------------------------------------------------------------------------
// rdp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> rtl/core/rdp_div.sv
// ----------------------------------------------------------------------------
// rdp_div
// Restoring divider, one quotient bit per cycle (24-bit dividend, 13-bit divisor).
// ----------------------------------------------------------------------------
module rdp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [12:0] divisor,
  output logic        busy,
  output logic [23:0] quotient
);
  logic [4:0]  cnt_r, cnt_nxt;
  logic [23:0] q_r, q_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [14:0] trial;

  assign trial = {rem_r, q_r[23]} - {2'b0, divisor};
  assign busy = (cnt_r != 5'd0);
  assign quotient = q_r;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = 5'd24;
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (busy) begin
      cnt_nxt = cnt_r - 5'd1;
      if (!trial[14]) begin
        rem_nxt = trial[13:0];
        q_nxt   = {q_r[22:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[12:0], q_r[23]};
        q_nxt   = {q_r[22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end
endmodule
